// ===== rtl/core/frg_pkg.sv =====
// Shared types and constants for the frame rate resolution governor.
// No dependencies.
`default_nettype none
package frg_pkg;
  localparam int HistDepth = 64;
  localparam int PosW = $clog2(HistDepth);
  localparam int SumW = 18 + PosW + 1;
  localparam logic [17:0] RingReset = 18'd11100;
  localparam logic [28:0] FpsNum = 29'd256000000;
  localparam logic [19:0] FpsMax = 20'd1048575;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegTarget = 3'd1;
  localparam logic [2:0] RegMaxTime = 3'd2;
  localparam logic [2:0] RegMinScale = 3'd3;
  localparam logic [2:0] RegMaxScale = 3'd4;
  localparam logic [2:0] RegGain = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WALK, ST_DIV_FPS, ST_DIV_RATIO, ST_GOAL, ST_SPRING,
    ST_VEL, ST_SCALE, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/frg_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module frg_ram #(
  parameter int Width = 18,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/frame_rate_resolution_governor.sv =====
// Top level of the frame rate resolution governor.
// Depends on frg_pkg and frg_ram.
`default_nettype none
// One frame time word in, one result word out. After reset the ring memory is
// swept to 11100 us before the first word is taken. Each word is then taken,
// the ring memory walked (sum and peak), and the frame rate and the ratio
// found by bit-serial divisions. When the governor is on, the goal and the
// spring-damper update follow; the velocity and scale steps are skipped when
// the scale does not step. Then the output register is loaded. The next word
// is taken once that register is free.
module frame_rate_resolution_governor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [17:0] in_frame_time_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_resolution_scale,
  output logic             out_scale_applied,
  output logic      [19:0] out_frames_per_second,
  output logic      [17:0] out_average_frame_us,
  output logic      [17:0] out_peak_frame_us,
  output logic             out_meeting_target,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);
  localparam int PW = frg_pkg::PosW;

  frg_pkg::state_t state_r, state_nxt;

  logic        en_r;
  logic [9:0]  tgt_r;
  logic [17:0] maxt_r;
  logic [15:0] mins_r, maxs_r;
  logic [11:0] gain_r;

  logic [PW-1:0] pos_r, cnt_r;
  logic [PW:0]   walk_r;
  logic [17:0]   t_r;
  logic [frg_pkg::SumW-1:0] sum_r;
  logic [17:0]   peak_r;
  logic [19:0]   fps_r;
  logic [15:0]   cur_r, goal_r;
  logic signed [19:0] vel_r;
  logic          applied_r;
  logic [5:0]    dcnt_r;
  logic [33:0]   quo_r;
  logic [33:0]   rem_r;
  logic [33:0]   dvd_r;
  logic signed [35:0] prod_r;
  logic signed [20:0] vnew_r;

  logic        ram_we;
  logic [PW-1:0] ram_wa, ram_ra;
  logic [17:0] ram_wd, ram_rd;

  frg_ram #(.Width(18), .Depth(frg_pkg::HistDepth)) u_ring (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  logic [9:0] tgt_eff;
  assign tgt_eff = (tgt_r == 10'd0) ? 10'd1 : tgt_r;

  // slot 0 is read on the same edge that writes it; forward the new word
  logic [17:0] walk_rd;
  assign walk_rd = (walk_r == (PW+1)'(1) && pos_r == PW'(1)) ? t_r : ram_rd;

  // ratio goal and spring terms
  logic [15:0] ratio;
  logic signed [17:0] goal_calc;
  logic signed [31:0] red_prod;
  logic signed [17:0] red;
  logic signed [17:0] inc;
  logic signed [17:0] diff;
  logic signed [17:0] mag;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frg_pkg::ST_CLEAR:     if (cnt_r == PW'(frg_pkg::HistDepth - 1))
                               state_nxt = frg_pkg::ST_IDLE;
      frg_pkg::ST_IDLE:      if (in_valid && !out_valid) state_nxt = frg_pkg::ST_WALK;
      frg_pkg::ST_WALK:      if (walk_r == (PW+1)'(frg_pkg::HistDepth))
                               state_nxt = frg_pkg::ST_DIV_FPS;
      frg_pkg::ST_DIV_FPS:   if (dcnt_r == 6'd0) state_nxt = frg_pkg::ST_DIV_RATIO;
      frg_pkg::ST_DIV_RATIO: if (dcnt_r == 6'd0)
                               state_nxt = en_r ? frg_pkg::ST_GOAL : frg_pkg::ST_OUT;
      frg_pkg::ST_GOAL:      state_nxt = frg_pkg::ST_SPRING;
      frg_pkg::ST_SPRING:    state_nxt = (mag >= 18'sd164) ? frg_pkg::ST_VEL
                                                           : frg_pkg::ST_OUT;
      frg_pkg::ST_VEL:       state_nxt = frg_pkg::ST_SCALE;
      frg_pkg::ST_SCALE:     state_nxt = frg_pkg::ST_OUT;
      frg_pkg::ST_OUT:       state_nxt = frg_pkg::ST_IDLE;
      default:               state_nxt = frg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_wa   = pos_r;
    ram_wd   = in_frame_time_us;
    ram_ra   = walk_r[PW-1:0];
    unique case (state_r)
      frg_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = cnt_r;
        ram_wd = frg_pkg::RingReset;
      end
      frg_pkg::ST_IDLE: begin
        in_ready = !out_valid;
        ram_we   = in_valid && !out_valid;
        ram_ra   = '0;
      end
      default: ;
    endcase
  end
  assign cfg_ready = 1'b1;

  assign ratio = (quo_r > 34'd65535) ? 16'hFFFF : quo_r[15:0];
  always_comb begin
    red = 18'sd4096 - 18'sd2 * (18'sd3891 - $signed({2'b0, ratio}));
    if (red < 0) red = '0;
    red_prod = $signed({16'b0, cur_r}) * red[13:0];
    inc = ($signed({2'b0, ratio}) - 18'sd4301) * 18'sd2;
    if (inc > 18'sd1638) inc = 18'sd1638;
    goal_calc = $signed({2'b0, goal_r});
    if (ratio < 16'd3891) begin
      goal_calc = 18'(red_prod >>> 12);
      if (goal_calc < $signed({2'b0, mins_r})) goal_calc = $signed({2'b0, mins_r});
    end else if (ratio > 16'd4301) begin
      goal_calc = $signed({2'b0, cur_r}) + inc;
      if (goal_calc > $signed({2'b0, maxs_r})) goal_calc = $signed({2'b0, maxs_r});
    end
    diff = $signed({2'b0, goal_r}) - $signed({2'b0, cur_r});
    mag  = (diff < 0) ? -diff : diff;
  end

  // spring, damping, and step
  logic signed [31:0] spring_p;
  logic signed [21:0] spring, damp, sd;
  logic signed [35:0] dv_p;
  logic signed [21:0] dv;
  logic signed [21:0] vsum;
  logic signed [19:0] vsat;
  logic signed [31:0] step_p;
  logic signed [19:0] step;
  logic signed [20:0] snew;
  logic [15:0] sclamp;
  always_comb begin
    spring_p = diff * $signed({1'b0, gain_r});
    spring = 22'(spring_p / 256);
    damp   = 22'(vel_r / 2);
    sd     = spring - damp;
    dv_p   = prod_r;
    dv     = 22'(dv_p / 65536);
    vsum   = 22'(vel_r) + dv;
    if (vsum > 22'sd524287) vsat = 20'sd524287;
    else if (vsum < -22'sd524288) vsat = -20'sd524288;
    else vsat = vsum[19:0];
    step_p = vnew_r * 32'sd1049;
    step   = 20'(step_p / 65536);
    snew   = $signed({5'b0, cur_r}) + 21'(step);
    if (snew < $signed({5'b0, mins_r})) sclamp = mins_r;
    else if (snew < $signed({5'b0, maxs_r})) sclamp = snew[15:0];
    else sclamp = maxs_r;
  end

  logic [34:0] rem_sh;
  assign rem_sh = {rem_r, dvd_r[33]};

  // fps value as the ratio dividend uses it, valid for the held or new rate
  function automatic logic [29:0] fps_r_next(input logic [33:0] q);
    logic [19:0] f;
    f = fps_r;
    if (t_r != 18'd0) f = (q > 34'(frg_pkg::FpsMax)) ? frg_pkg::FpsMax : q[19:0];
    fps_r_next = {10'b0, f};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frg_pkg::ST_CLEAR;
      en_r <= 1'b1; tgt_r <= 10'd90; maxt_r <= 18'd11111;
      mins_r <= 16'd8192; maxs_r <= 16'd16384; gain_r <= 12'd512;
      pos_r <= '0; cnt_r <= '0; fps_r <= '0;
      cur_r <= 16'd16384; goal_r <= 16'd16384; vel_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          frg_pkg::RegEnable:   en_r   <= cfg_data[0];
          frg_pkg::RegTarget:   tgt_r  <= cfg_data[9:0];
          frg_pkg::RegMaxTime:  maxt_r <= cfg_data;
          frg_pkg::RegMinScale: mins_r <= cfg_data[15:0];
          frg_pkg::RegMaxScale: maxs_r <= cfg_data[15:0];
          frg_pkg::RegGain:     gain_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        frg_pkg::ST_CLEAR: cnt_r <= cnt_r + PW'(1);
        frg_pkg::ST_IDLE: begin
          if (in_valid && !out_valid) begin
            t_r    <= in_frame_time_us;
            pos_r  <= pos_r + PW'(1);
            walk_r <= (PW+1)'(1);
            sum_r  <= '0;
            peak_r <= '0;
          end
        end
        frg_pkg::ST_WALK: begin
          // data for index walk_r-1 arrives now
          sum_r <= sum_r + frg_pkg::SumW'(walk_rd);
          if (walk_rd > peak_r) peak_r <= walk_rd;
          walk_r <= walk_r + (PW+1)'(1);
          if (walk_r == (PW+1)'(frg_pkg::HistDepth)) begin
            dcnt_r <= 6'd29;
            dvd_r  <= {5'b0, frg_pkg::FpsNum} << 5;
            rem_r  <= '0;
            quo_r  <= '0;
          end
        end
        frg_pkg::ST_DIV_FPS, frg_pkg::ST_DIV_RATIO: begin
          if (dcnt_r != 6'd0) begin
            dvd_r  <= dvd_r << 1;
            dcnt_r <= dcnt_r - 6'd1;
            if (rem_sh >= ((state_r == frg_pkg::ST_DIV_FPS) ? 35'(t_r) : 35'(tgt_eff))) begin
              rem_r <= 34'(rem_sh - ((state_r == frg_pkg::ST_DIV_FPS) ? 35'(t_r)
                                                                      : 35'(tgt_eff)));
              quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= rem_sh[33:0];
              quo_r <= {quo_r[32:0], 1'b0};
            end
          end else if (state_r == frg_pkg::ST_DIV_FPS) begin
            if (t_r != 18'd0) fps_r <= (quo_r > 34'(frg_pkg::FpsMax)) ? frg_pkg::FpsMax
                                                                       : quo_r[19:0];
            dcnt_r <= 6'd34;
            dvd_r  <= {fps_r_next(quo_r), 4'b0};
            rem_r  <= '0;
            quo_r  <= '0;
          end
        end
        frg_pkg::ST_GOAL: begin
          goal_r    <= goal_calc[15:0];
          applied_r <= 1'b0;
        end
        frg_pkg::ST_SPRING: begin
          applied_r <= (mag >= 18'sd164);
          prod_r    <= 36'(sd) * 36'sd1049;
        end
        frg_pkg::ST_VEL: begin
          vel_r  <= vsat;
          vnew_r <= 21'(vsat);
        end
        frg_pkg::ST_SCALE: begin
          cur_r  <= sclamp;
          goal_r <= sclamp;
        end
        frg_pkg::ST_OUT: begin
          out_valid             <= 1'b1;
          out_resolution_scale  <= cur_r;
          out_scale_applied     <= en_r && applied_r;
          out_frames_per_second <= fps_r;
          out_average_frame_us  <= 18'(sum_r >> PW);
          out_peak_frame_us     <= peak_r;
          out_meeting_target    <= (fps_r >= {2'b0, tgt_eff, 8'b0}) &&
                                   (18'(sum_r >> PW) <= maxt_r);
        end
        default: ;
      endcase
      if (state_r == frg_pkg::ST_IDLE) applied_r <= 1'b0;
    end
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result before work done");
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != frg_pkg::ST_IDLE) |-> !in_ready) else $error("word taken while busy");
  a_scale_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frg_pkg::ST_SCALE) |=> (cur_r == goal_r)) else $error("goal not tied");
`endif
endmodule
`default_nettype wire
